[design/scc_pkg.sv]
// Shared types and constants of the strongly connected components unit
package scc_pkg;

    localparam int NODE_W             = 10;
    localparam int NCNT_W             = 11;
    localparam int MAX_NODES          = 1024;
    localparam int MAX_EDGES_DEFAULT  = 4096;

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_COMP  = 2'd1,
        FN_QUERY = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_QRY, S_DONE,
        S_FILT_RD, S_FILT_WR, S_ZERO,
        S_CNT_LST, S_CNT_KEY, S_CNT_OFF, S_CNT_WR,
        S_PFX_RD, S_PFX_WR,
        S_PLC_LST, S_PLC_KEY, S_PLC_CUR, S_PLC_WR,
        S_SEED, S_SEED_RD, S_SEED_PUSH,
        S_POP, S_FRAME, S_VIS, S_OFF_LO, S_OFF_HI,
        S_EDGE, S_EDGE_LST, S_EDGE_PUSH
    } t_state;

    // one stack entry: node, finish flag or inherited label, new-component flag
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] tag;
        logic              fresh;
    } t_frame;

    typedef struct packed {
        t_func             func;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] tgt;
        logic [NODE_W-1:0] qnode;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] label;
        logic [NCNT_W-1:0] total;
        t_status           status;
    } t_res;

endpackage

[design/scc_engine.sv]
// Memory-based sequencer: edge store, counting sorts and both depth-first passes
module scc_engine #(
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  scc_pkg::t_cmd               i_cmd,
    input  logic [scc_pkg::NCNT_W-1:0]  i_node_count,
    input  logic                        i_take,
    output logic                        o_idle,
    output logic                        o_done,
    output scc_pkg::t_res               o_res
);
    localparam int NW  = scc_pkg::NODE_W;
    localparam int NCW = scc_pkg::NCNT_W;
    localparam int MN  = scc_pkg::MAX_NODES;
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int IW  = (CW > NCW) ? CW : NCW;
    localparam int SD  = 2 * MN + MAX_EDGES;
    localparam int SW  = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    scc_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_m, n_m;
    logic [CW-1:0]   r_acc, n_acc;
    logic [CW-1:0]   r_e, n_e;
    logic [CW-1:0]   r_hi, n_hi;
    logic [NW-1:0]   r_key, n_key;
    logic [EW-1:0]   r_eidx, n_eidx;
    logic [SPW-1:0]  r_sp, n_sp;
    logic [NCW-1:0]  r_fc, n_fc;
    logic [NCW-1:0]  r_k, n_k;
    logic [NW-1:0]   r_node, n_node;
    logic [NW-1:0]   r_tag, n_tag;
    logic            r_fresh, n_fresh;
    logic [NW-1:0]   r_lab, n_lab;
    logic            r_pass, n_pass;
    logic            r_grp, n_grp;
    logic [NCW-1:0]  r_total, n_total;
    logic [NW-1:0]   r_res_label, n_res_label;
    scc_pkg::t_status r_res_status, n_res_status;

    // memory ports
    logic                  edge_we;
    logic [EW-1:0]         edge_wa, esrc_ra, etgt_ra;
    logic [NW-1:0]         esrc_wd, etgt_wd, esrc_rd, etgt_rd;
    logic                  la_we, lb_we;
    logic [EW-1:0]         la_wa, la_wd, la_ra, la_rd, lb_wa, lb_wd, lb_ra, lb_rd;
    logic                  offs_we, cur_we;
    logic [NCW-1:0]        offs_wa, offs_ra, cur_wa, cur_ra;
    logic [CW-1:0]         offs_wd, offs_rd, cur_wd, cur_rd;
    logic                  vis_we, vis_wd, vis_rd;
    logic [NW-1:0]         vis_wa, vis_ra;
    logic                  stk_we;
    logic [SW-1:0]         stk_wa, stk_ra;
    scc_pkg::t_frame       stk_wd, stk_rd;
    logic                  fo_we, lab_we;
    logic [NW-1:0]         fo_wa, fo_wd, fo_ra, fo_rd, lab_wa, lab_wd, lab_ra, lab_rd;

    logic [NW-1:0]         m_esrc [MAX_EDGES];
    logic [NW-1:0]         m_etgt [MAX_EDGES];
    logic [EW-1:0]         m_la   [MAX_EDGES];
    logic [EW-1:0]         m_lb   [MAX_EDGES];
    logic [CW-1:0]         m_offs [MN+1];
    logic [CW-1:0]         m_cur  [MN+1];
    logic                  m_vis  [MN];
    scc_pkg::t_frame       m_stk  [SD];
    logic [NW-1:0]         m_fo   [MN];
    logic [NW-1:0]         m_lab  [MN];

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_esrc[edge_wa] <= esrc_wd;
            m_etgt[edge_wa] <= etgt_wd;
        end
        esrc_rd <= m_esrc[esrc_ra];
        etgt_rd <= m_etgt[etgt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (la_we) begin
            m_la[la_wa] <= la_wd;
        end
        la_rd <= m_la[la_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lb_we) begin
            m_lb[lb_wa] <= lb_wd;
        end
        lb_rd <= m_lb[lb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (offs_we) begin
            m_offs[offs_wa] <= offs_wd;
        end
        offs_rd <= m_offs[offs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            m_cur[cur_wa] <= cur_wd;
        end
        cur_rd <= m_cur[cur_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            m_vis[vis_wa] <= vis_wd;
        end
        vis_rd <= m_vis[vis_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            m_stk[stk_wa] <= stk_wd;
        end
        stk_rd <= m_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fo_we) begin
            m_fo[fo_wa] <= fo_wd;
        end
        fo_rd <= m_fo[fo_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            m_lab[lab_wa] <= lab_wd;
        end
        lab_rd <= m_lab[lab_ra];
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::S_IDLE;
            r_cnt   <= '0;
            r_total <= '0;
            r_sp    <= '0;
            r_fc    <= '0;
            r_k     <= '0;
            r_pass  <= 1'b0;
            r_grp   <= 1'b0;
            r_i     <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_sp    <= n_sp;
            r_fc    <= n_fc;
            r_k     <= n_k;
            r_pass  <= n_pass;
            r_grp   <= n_grp;
            r_i     <= n_i;
            r_m     <= n_m;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_e          <= n_e;
        r_hi         <= n_hi;
        r_key        <= n_key;
        r_eidx       <= n_eidx;
        r_node       <= n_node;
        r_tag        <= n_tag;
        r_fresh      <= n_fresh;
        r_lab        <= n_lab;
        r_res_label  <= n_res_label;
        r_res_status <= n_res_status;
    end

    // sequence the command
    always_comb begin
        logic [EW-1:0]   e_sel;
        logic [NW-1:0]   k_sel;
        logic [CW-1:0]   sum;
        logic [NW-1:0]   lab;
        scc_pkg::t_frame f;

        n_state = r_state;  n_i = r_i;      n_cnt = r_cnt;   n_m = r_m;
        n_acc = r_acc;      n_e = r_e;      n_hi = r_hi;     n_key = r_key;
        n_eidx = r_eidx;    n_sp = r_sp;    n_fc = r_fc;     n_k = r_k;
        n_node = r_node;    n_tag = r_tag;  n_fresh = r_fresh;
        n_lab = r_lab;      n_pass = r_pass; n_grp = r_grp;  n_total = r_total;
        n_res_label = r_res_label;  n_res_status = r_res_status;

        edge_we = 1'b0;  edge_wa = r_cnt[EW-1:0];
        esrc_wd = i_cmd.src;  etgt_wd = i_cmd.tgt;
        esrc_ra = '0;  etgt_ra = '0;
        la_we = 1'b0;  la_wa = '0;  la_wd = '0;  la_ra = '0;
        lb_we = 1'b0;  lb_wa = '0;  lb_wd = '0;  lb_ra = '0;
        offs_we = 1'b0;  offs_wa = '0;  offs_wd = '0;  offs_ra = '0;
        cur_we = 1'b0;   cur_wa = '0;   cur_wd = '0;   cur_ra = '0;
        vis_we = 1'b0;   vis_wa = '0;   vis_wd = 1'b0; vis_ra = '0;
        stk_we = 1'b0;   stk_wa = r_sp[SW-1:0];  stk_wd = '0;  stk_ra = '0;
        fo_we = 1'b0;    fo_wa = r_fc[NW-1:0];   fo_wd = '0;   fo_ra = '0;
        lab_we = 1'b0;   lab_wa = '0;   lab_wd = '0;   lab_ra = i_cmd.qnode;

        e_sel = r_grp ? lb_rd : la_rd;
        k_sel = r_grp ? etgt_rd : esrc_rd;
        sum   = r_acc + offs_rd;
        f     = stk_rd;
        lab   = r_fresh ? r_k[NW-1:0] : r_tag;

        case (r_state)
            scc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_res_label  = '0;
                    n_res_status = scc_pkg::STS_OK;
                    n_state      = scc_pkg::S_DONE;
                    case (i_cmd.func)
                        scc_pkg::FN_ADD: begin
                            if ({1'b0, i_cmd.src} >= i_node_count ||
                                {1'b0, i_cmd.tgt} >= i_node_count) begin
                                n_res_status = scc_pkg::STS_RANGE;
                            end else if (r_cnt >= CW'(MAX_EDGES)) begin
                                n_res_status = scc_pkg::STS_FULL;
                            end else begin
                                edge_we = 1'b1;
                                n_cnt   = r_cnt + 1'b1;
                            end
                        end
                        scc_pkg::FN_QUERY: begin
                            if ({1'b0, i_cmd.qnode} >= i_node_count) begin
                                n_res_status = scc_pkg::STS_RANGE;
                            end else begin
                                n_state = scc_pkg::S_QRY;
                            end
                        end
                        scc_pkg::FN_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                            n_i     = '0;
                            n_m     = '0;
                            n_grp   = 1'b0;
                            n_state = scc_pkg::S_FILT_RD;
                        end
                    endcase
                end
            end
            scc_pkg::S_QRY: begin
                n_res_label = lab_rd;
                n_state     = scc_pkg::S_DONE;
            end
            scc_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = scc_pkg::S_IDLE;
                end
            end
            // keep edges whose ends lie below the node count
            scc_pkg::S_FILT_RD: begin
                if (r_i == IW'(r_cnt)) begin
                    n_i     = '0;
                    n_state = scc_pkg::S_ZERO;
                end else begin
                    esrc_ra = r_i[EW-1:0];
                    etgt_ra = r_i[EW-1:0];
                    n_state = scc_pkg::S_FILT_WR;
                end
            end
            scc_pkg::S_FILT_WR: begin
                if ({1'b0, esrc_rd} < i_node_count && {1'b0, etgt_rd} < i_node_count) begin
                    la_we = 1'b1;
                    la_wa = r_m[EW-1:0];
                    la_wd = r_i[EW-1:0];
                    n_m   = r_m + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = scc_pkg::S_FILT_RD;
            end
            // clear offsets and visited marks
            scc_pkg::S_ZERO: begin
                offs_we = 1'b1;
                offs_wa = r_i[NCW-1:0];
                if (r_i < IW'(i_node_count)) begin
                    vis_we = 1'b1;
                    vis_wa = r_i[NW-1:0];
                end
                if (r_i == IW'(i_node_count)) begin
                    n_i     = '0;
                    n_state = scc_pkg::S_CNT_LST;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            // count edges per key
            scc_pkg::S_CNT_LST: begin
                if (r_i == IW'(r_m)) begin
                    n_i     = '0;
                    n_acc   = '0;
                    n_state = scc_pkg::S_PFX_RD;
                end else begin
                    la_ra   = r_i[EW-1:0];
                    lb_ra   = r_i[EW-1:0];
                    n_state = scc_pkg::S_CNT_KEY;
                end
            end
            scc_pkg::S_CNT_KEY: begin
                esrc_ra = e_sel;
                etgt_ra = e_sel;
                n_eidx  = e_sel;
                n_state = scc_pkg::S_CNT_OFF;
            end
            scc_pkg::S_CNT_OFF: begin
                n_key   = k_sel;
                offs_ra = {1'b0, k_sel} + 1'b1;
                n_state = scc_pkg::S_CNT_WR;
            end
            scc_pkg::S_CNT_WR: begin
                offs_we = 1'b1;
                offs_wa = {1'b0, r_key} + 1'b1;
                offs_wd = offs_rd + 1'b1;
                n_i     = r_i + 1'b1;
                n_state = scc_pkg::S_CNT_LST;
            end
            // running sum into offsets and cursors
            scc_pkg::S_PFX_RD: begin
                offs_ra = r_i[NCW-1:0];
                n_state = scc_pkg::S_PFX_WR;
            end
            scc_pkg::S_PFX_WR: begin
                offs_we = 1'b1;
                offs_wa = r_i[NCW-1:0];
                offs_wd = sum;
                cur_we  = 1'b1;
                cur_wa  = r_i[NCW-1:0];
                cur_wd  = sum;
                n_acc   = sum;
                if (r_i == IW'(i_node_count)) begin
                    n_i     = '0;
                    n_state = scc_pkg::S_PLC_LST;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = scc_pkg::S_PFX_RD;
                end
            end
            // stable placement through the cursors
            scc_pkg::S_PLC_LST: begin
                if (r_i == IW'(r_m)) begin
                    n_i  = '0;
                    n_sp = '0;
                    if (r_grp) begin
                        n_pass  = 1'b1;
                        n_k     = '0;
                        n_state = scc_pkg::S_SEED_RD;
                    end else begin
                        n_pass  = 1'b0;
                        n_fc    = '0;
                        n_state = scc_pkg::S_SEED;
                    end
                end else begin
                    la_ra   = r_i[EW-1:0];
                    lb_ra   = r_i[EW-1:0];
                    n_state = scc_pkg::S_PLC_KEY;
                end
            end
            scc_pkg::S_PLC_KEY: begin
                esrc_ra = e_sel;
                etgt_ra = e_sel;
                n_eidx  = e_sel;
                n_state = scc_pkg::S_PLC_CUR;
            end
            scc_pkg::S_PLC_CUR: begin
                n_key   = k_sel;
                cur_ra  = {1'b0, k_sel};
                n_state = scc_pkg::S_PLC_WR;
            end
            scc_pkg::S_PLC_WR: begin
                if (r_grp) begin
                    la_we = 1'b1;
                    la_wa = cur_rd[EW-1:0];
                    la_wd = r_eidx;
                end else begin
                    lb_we = 1'b1;
                    lb_wa = cur_rd[EW-1:0];
                    lb_wd = r_eidx;
                end
                cur_we  = 1'b1;
                cur_wa  = {1'b0, r_key};
                cur_wd  = cur_rd + 1'b1;
                n_i     = r_i + 1'b1;
                n_state = scc_pkg::S_PLC_LST;
            end
            // forward pass seeds: every node, highest on top
            scc_pkg::S_SEED: begin
                if (r_i == IW'(i_node_count)) begin
                    n_state = scc_pkg::S_POP;
                end else begin
                    stk_we      = 1'b1;
                    stk_wd.node = r_i[NW-1:0];
                    n_sp        = r_sp + 1'b1;
                    n_i         = r_i + 1'b1;
                end
            end
            // reverse pass seeds: finish order, last finished on top
            scc_pkg::S_SEED_RD: begin
                if (r_i == IW'(r_fc)) begin
                    n_state = scc_pkg::S_POP;
                end else begin
                    fo_ra   = r_i[NW-1:0];
                    n_state = scc_pkg::S_SEED_PUSH;
                end
            end
            scc_pkg::S_SEED_PUSH: begin
                stk_we       = 1'b1;
                stk_wd.node  = fo_rd;
                stk_wd.fresh = 1'b1;
                n_sp         = r_sp + 1'b1;
                n_i          = r_i + 1'b1;
                n_state      = scc_pkg::S_SEED_RD;
            end
            scc_pkg::S_POP: begin
                if (r_sp == '0) begin
                    if (r_pass) begin
                        n_total      = r_k;
                        n_res_label  = '0;
                        n_res_status = scc_pkg::STS_OK;
                        n_state      = scc_pkg::S_DONE;
                    end else begin
                        n_grp   = 1'b1;
                        n_i     = '0;
                        n_state = scc_pkg::S_ZERO;
                    end
                end else begin
                    stk_ra  = SW'(r_sp - 1'b1);
                    n_sp    = r_sp - 1'b1;
                    n_state = scc_pkg::S_FRAME;
                end
            end
            scc_pkg::S_FRAME: begin
                n_node  = f.node;
                n_tag   = f.tag;
                n_fresh = f.fresh;
                if (!r_pass && f.tag[0]) begin
                    fo_we   = 1'b1;
                    fo_wd   = f.node;
                    n_fc    = r_fc + 1'b1;
                    n_state = scc_pkg::S_POP;
                end else begin
                    vis_ra  = f.node;
                    n_state = scc_pkg::S_VIS;
                end
            end
            scc_pkg::S_VIS: begin
                if (vis_rd) begin
                    n_state = scc_pkg::S_POP;
                end else begin
                    vis_we  = 1'b1;
                    vis_wa  = r_node;
                    vis_wd  = 1'b1;
                    offs_ra = {1'b0, r_node};
                    if (r_pass) begin
                        lab_we = 1'b1;
                        lab_wa = r_node;
                        lab_wd = lab;
                        n_lab  = lab;
                        if (r_fresh) begin
                            n_k = r_k + 1'b1;
                        end
                    end else begin
                        stk_we      = 1'b1;
                        stk_wd.node = r_node;
                        stk_wd.tag  = NW'(1);
                        n_sp        = r_sp + 1'b1;
                        n_lab       = '0;
                    end
                    n_state = scc_pkg::S_OFF_LO;
                end
            end
            scc_pkg::S_OFF_LO: begin
                n_e     = offs_rd;
                offs_ra = {1'b0, r_node} + 1'b1;
                n_state = scc_pkg::S_OFF_HI;
            end
            scc_pkg::S_OFF_HI: begin
                n_hi    = offs_rd;
                n_state = scc_pkg::S_EDGE;
            end
            // push the far end of each adjacent edge
            scc_pkg::S_EDGE: begin
                if (r_e >= r_hi) begin
                    n_state = scc_pkg::S_POP;
                end else begin
                    la_ra   = r_e[EW-1:0];
                    lb_ra   = r_e[EW-1:0];
                    n_state = scc_pkg::S_EDGE_LST;
                end
            end
            scc_pkg::S_EDGE_LST: begin
                esrc_ra = r_pass ? la_rd : lb_rd;
                etgt_ra = r_pass ? la_rd : lb_rd;
                n_state = scc_pkg::S_EDGE_PUSH;
            end
            scc_pkg::S_EDGE_PUSH: begin
                stk_we      = 1'b1;
                stk_wd.node = r_pass ? esrc_rd : etgt_rd;
                stk_wd.tag  = r_lab;
                n_sp        = r_sp + 1'b1;
                n_e         = r_e + 1'b1;
                n_state     = scc_pkg::S_EDGE;
            end
            default: begin
                n_state = scc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle       = (r_state == scc_pkg::S_IDLE);
    assign o_done       = (r_state == scc_pkg::S_DONE);
    assign o_res.label  = r_res_label;
    assign o_res.total  = r_total;
    assign o_res.status = r_res_status;

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SD))
        else $error("walk stack pointer beyond its depth");

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_EDGES))
        else $error("edge count beyond store depth");

    a_pop_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scc_pkg::S_POP && r_sp != '0) |=> (r_state == scc_pkg::S_FRAME))
        else $error("pop did not lead to frame decode");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scc_pkg::S_POP && r_sp == '0 && r_pass) |=>
        (r_total <= i_node_count))
        else $error("more components than nodes");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !i_take) |=> (o_done && $stable(o_res)))
        else $error("result changed before it was taken");

endmodule

[design/strongly_connected_components_unit.sv]
// Strongly connected components unit: handshake, node count register and output register
//
// Input channel (i_in_valid / o_in_ready) carries one word per command: add an edge,
// compute components, query a node's component, or clear the edge store. Every word
// gives exactly one result word on the output channel (o_out_valid / i_out_ready).
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the node count; it is
// always ready and must only be written while no command is outstanding.
// Add, clear and an out-of-range query go from acceptance to the done state and then to the
// output register; an in-range query passes a label read state first. The next word is
// accepted once the sequencer is idle, even while the output register still holds an
// untaken result. Compute runs through memories with one write and one registered read
// port each; its run time grows with stored edges, edges in range and nodes, and is set
// by the two counting sorts and the stack walk, one read per pop and one write per push.
// Reset (synchronous, active low) empties the edge store, zeroes the component total
// and sets the node count to 1; no memory is swept. Labels read before any compute
// are undefined. When the receiver stalls, the result is held in the output register
// and the sequencer waits with the next result until that register empties.
module strongly_connected_components_unit #(
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_func,
    input  logic [scc_pkg::NODE_W-1:0]  i_edge_source,
    input  logic [scc_pkg::NODE_W-1:0]  i_edge_target,
    input  logic [scc_pkg::NODE_W-1:0]  i_query_node,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [scc_pkg::NODE_W-1:0]  o_component_label,
    output logic [scc_pkg::NCNT_W-1:0]  o_component_total,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scc_pkg::NCNT_W-1:0]  i_cfg_node_count
);
    localparam int NCW = scc_pkg::NCNT_W;

    logic [NCW-1:0]  r_node_count;
    logic [NCW-1:0]  eff_count;
    logic            r_out_valid;
    scc_pkg::t_res   r_out;
    scc_pkg::t_cmd   cmd;
    scc_pkg::t_res   eng_res;
    logic            eng_idle, eng_done, take, start;

    // hold the node count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NCW'(1);
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_node_count;
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamp the count into one to the node limit
    always_comb begin
        if (r_node_count == '0) begin
            eff_count = NCW'(1);
        end else if (r_node_count > NCW'(scc_pkg::MAX_NODES)) begin
            eff_count = NCW'(scc_pkg::MAX_NODES);
        end else begin
            eff_count = r_node_count;
        end
    end

    assign o_in_ready = eng_idle;
    assign start      = i_in_valid && eng_idle;
    assign cmd.func   = scc_pkg::t_func'(i_func);
    assign cmd.src    = i_edge_source;
    assign cmd.tgt    = i_edge_target;
    assign cmd.qnode  = i_query_node;
    assign take       = eng_done && (!r_out_valid || i_out_ready);

    scc_engine #(
        .MAX_EDGES (MAX_EDGES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmd        (cmd),
        .i_node_count (eff_count),
        .i_take       (take),
        .o_idle       (eng_idle),
        .o_done       (eng_done),
        .o_res        (eng_res)
    );

    // advance the result word into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_component_label = r_out.label;
    assign o_component_total = r_out.total;
    assign o_status          = r_out.status;

endmodule
